@@ design/window_drag_hit_test_engine_defines.svh @@
// Assertion macros for the window drag hit-test engine.
`ifndef WINDOW_DRAG_HIT_TEST_ENGINE_DEFINES_SVH
`define WINDOW_DRAG_HIT_TEST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define WD_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define WD_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define WD_ASSERT_IMPL(label, clk, rst_n, prop)
`define WD_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ design/wdht_pkg.sv @@
// Shared types, constants and helpers for the window drag hit-test engine.
package wdht_pkg;
    localparam int SLOTS       = 8;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BAR_HEIGHT  = 24;
    localparam int CURSOR_SIZE = 14;
    localparam int CW          = 18;

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_MARK   = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SCAN  = 10'b0000000010,
        ST_PRESS = 10'b0000000100,
        ST_DRAG  = 10'b0000001000,
        ST_MOVE  = 10'b0000010000,
        ST_CUR0  = 10'b0000100000,
        ST_CUR1  = 10'b0001000000,
        ST_EMIT  = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_PLACE = 10'b1000000000
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic do_create;
        logic do_mark;
        logic scan_step;
        logic press;
        logic drag_calc;
        logic move;
        logic place;
        logic cur0;
        logic cur1;
        logic emit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       scan_last;
        logic       hit_found;
        logic       press_edge;
        logic       release_drag;
        logic       drag_on;
        logic       need_move;
        logic       ptr_moved;
    } stat_t;

    function automatic coord_t sat15(input coord_t v);
        if (v < -coord_t'(16384)) return -coord_t'(16384);
        if (v > coord_t'(16383)) return coord_t'(16383);
        return v;
    endfunction
endpackage

@@ design/window_drag_hit_test_engine.sv @@
// Steps: create/mark go from scan straight to emit and output; a tick adds drag, move,
// a place step when the dragged window moves, cursor steps, and a slot scan plus press on a press edge.
// Throughput: one item at a time; the slot scan gives the longest items.
// The next item is taken while the last result waits in the output register.
// Reset (rst_n low, async): window table empty, drag off, dirty box clear,
// screen 1024 x 768.
module window_drag_hit_test_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // action
    input  logic [79:0] s_axis_tdata,  // pos_x, pos_y, size_w, size_h, ptr_x, ptr_y, left_button
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // create_ok, slot, redraw, dirty_x/y/w/h, drag_active,
                                       // drag_slot
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    import wdht_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic        busy, in_fire, out_free;
    logic [60:0] result;
    logic        ovld_reg;
    logic [60:0] odata_reg;

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovld_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    wdht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .stat(stat), .cmd(cmd), .busy(busy)
    );

    wdht_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
        .in_action(s_axis_tuser),
        .in_pos_x(s_axis_tdata[13:0]), .in_pos_y(s_axis_tdata[27:14]),
        .in_size_w(s_axis_tdata[40:28]), .in_size_h(s_axis_tdata[53:41]),
        .in_ptr_x(s_axis_tdata[65:54]), .in_ptr_y(s_axis_tdata[77:66]),
        .in_left(s_axis_tdata[78]),
        .result(result)
    );

    // hold the result until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (cmd.out_load)
            ovld_reg <= 1'b1;
        else if (m_axis_tready)
            ovld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            odata_reg <= result;
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {3'b000, odata_reg};
endmodule

@@ design/wdht_ctrl.sv @@
// Sequencer for one item of the window drag hit-test engine.
module wdht_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_free,
    input  wdht_pkg::stat_t stat,
    output wdht_pkg::cmd_t  cmd,
    output logic            busy
);
    import wdht_pkg::*;
    `include "window_drag_hit_test_engine_defines.svh"

    state_t state_reg, state_next;

    // advance one step per cycle, but wait in idle for an item and in output for a free output register
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.action != ACT_TICK)
                    state_next = ST_EMIT;
                else if (!stat.press_edge)
                    state_next = ST_DRAG;
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                        state_next = ST_PRESS;
                end
            end
            ST_PRESS:
            begin
                cmd.press  = 1'b1;
                state_next = ST_DRAG;
            end
            ST_DRAG:
            begin
                cmd.drag_calc = 1'b1;
                state_next    = ST_MOVE;
            end
            ST_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = stat.need_move ? ST_PLACE : ST_CUR0;
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_CUR0;
            end
            ST_CUR0:
            begin
                cmd.cur0   = 1'b1;
                state_next = ST_CUR1;
            end
            ST_CUR1:
            begin
                cmd.cur1   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.action == ACT_CREATE)
                    cmd.do_create = 1'b1;
                else if (stat.action == ACT_MARK)
                    cmd.do_mark = 1'b1;
                else if (stat.action == ACT_TICK)
                    cmd.emit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `WD_ASSERT_IMPL(a_onehot, clk, rst_n, $onehot(state_reg))
    `WD_ASSERT_IMPL(a_load_idle, clk, rst_n, cmd.load |-> state_reg == ST_IDLE)
    `WD_ASSERT_IMPL(a_out_then_idle, clk, rst_n, cmd.out_load |=> state_reg == ST_IDLE)
endmodule

@@ design/wdht_datapath.sv @@
// Window table, drag state and dirty box datapath.
module wdht_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wdht_pkg::cmd_t         cmd,
    output wdht_pkg::stat_t        stat,
    input  logic                   cfg_we,
    input  logic                   cfg_idx,
    input  logic [12:0]            cfg_val,
    input  logic [1:0]             in_action,
    input  logic signed [13:0]     in_pos_x,
    input  logic signed [13:0]     in_pos_y,
    input  logic [12:0]            in_size_w,
    input  logic [12:0]            in_size_h,
    input  logic [11:0]            in_ptr_x,
    input  logic [11:0]            in_ptr_y,
    input  logic                   in_left,
    output logic [60:0]            result
);
    import wdht_pkg::*;

    logic [12:0] scr_w_reg, scr_h_reg;
    logic [1:0]  act_reg;
    logic signed [13:0] px_reg, py_reg;
    logic [12:0] sw_reg, sh_reg;
    logic [11:0] mx_reg, my_reg;
    logic        lb_reg;

    logic [SLOTS-1:0]   used_reg;
    logic signed [13:0] wl_reg [SLOTS];
    logic signed [13:0] wt_reg [SLOTS];
    logic [12:0]        ww_reg [SLOTS];
    logic [12:0]        wh_reg [SLOTS];
    logic [31:0]        wz_reg [SLOTS];
    logic [31:0]        lnext_reg;
    logic               drag_reg;
    logic [SLOT_W-1:0]  didx_reg;
    logic signed [13:0] gdx_reg, gdy_reg;
    logic               pleft_reg;
    logic [11:0]        pmx_reg, pmy_reg;
    logic               bv_reg;
    coord_t             bx0_reg, by0_reg, bx1_reg, by1_reg;
    logic [SLOT_W-1:0]  scan_reg;
    logic               best_ok_reg;
    logic [SLOT_W-1:0]  best_reg;
    logic signed [13:0] nx_reg, ny_reg;
    logic               ok_reg, redraw_reg;
    logic [SLOT_W-1:0]  oslot_reg;
    logic [12:0]        ox_reg, oy_reg, ow_reg, oh_reg;

    // first free slot
    logic              free_ok;
    logic [SLOT_W-1:0] free_idx;
    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!used_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = SLOT_W'(i);
            end
    end

    // hit test of the slot under scan
    coord_t cx, cy, l, t, r, cx0, cy0;
    logic   hit;
    always_comb
    begin
        cx  = coord_t'(mx_reg);
        cy  = coord_t'(my_reg);
        l   = coord_t'(wl_reg[scan_reg]);
        t   = coord_t'(wt_reg[scan_reg]);
        r   = l + coord_t'(ww_reg[scan_reg]);
        cx0 = r - coord_t'(BAR_HEIGHT - 4);
        cy0 = t - coord_t'(BAR_HEIGHT - 4);
        hit = used_reg[scan_reg] && cx >= l && cx < r
              && cy >= t - coord_t'(BAR_HEIGHT) && cy < t
              && !(cx >= cx0 && cx < cx0 + coord_t'(BAR_HEIGHT - 8)
                   && cy >= cy0 && cy < cy0 + coord_t'(BAR_HEIGHT - 8));
    end

    // drag clamp for the dragged slot
    coord_t dnx, dny, dw, dh;
    always_comb
    begin
        dw  = coord_t'(ww_reg[didx_reg]);
        dh  = coord_t'(wh_reg[didx_reg]);
        dnx = coord_t'(mx_reg) - coord_t'(gdx_reg);
        dny = coord_t'(my_reg) - coord_t'(gdy_reg);
        if (dnx < 0) dnx = '0;
        if (dny < coord_t'(BAR_HEIGHT)) dny = coord_t'(BAR_HEIGHT);
        if (dnx + dw > coord_t'(scr_w_reg)) dnx = coord_t'(scr_w_reg) - dw;
        if (dny + dh > coord_t'(scr_h_reg)) dny = coord_t'(scr_h_reg) - dh;
    end

    // pick the box to union this cycle
    coord_t ax, ay, aw, ah, ax0, ay0, ax1, ay1;
    logic   add_en;
    logic [SLOT_W-1:0] wsel;
    always_comb
    begin
        add_en = 1'b0;
        wsel   = cmd.press ? best_reg : didx_reg;
        ax = coord_t'(wl_reg[wsel]) - coord_t'(2);
        ay = coord_t'(wt_reg[wsel]) - coord_t'(BAR_HEIGHT + 2);
        aw = coord_t'(ww_reg[wsel]) + coord_t'(4);
        ah = coord_t'(wh_reg[wsel]) + coord_t'(BAR_HEIGHT + 4);
        if (cmd.do_mark)
        begin
            add_en = 1'b1;
            ax = coord_t'(px_reg); ay = coord_t'(py_reg);
            aw = coord_t'(sw_reg); ah = coord_t'(sh_reg);
        end
        else if (cmd.press)
            add_en = best_ok_reg;
        else if (cmd.move)
            add_en = stat.need_move;
        else if (cmd.place)
            add_en = 1'b1;
        else if (cmd.cur0 || cmd.cur1)
        begin
            add_en = stat.ptr_moved;
            ax = cmd.cur0 ? coord_t'(pmx_reg) - coord_t'(2) : coord_t'(mx_reg) - coord_t'(2);
            ay = cmd.cur0 ? coord_t'(pmy_reg) - coord_t'(2) : coord_t'(my_reg) - coord_t'(2);
            aw = coord_t'(CURSOR_SIZE + 4);
            ah = coord_t'(CURSOR_SIZE + 4);
        end
        ax0 = sat15(ax);
        ay0 = sat15(ay);
        ax1 = sat15(ax + aw);
        ay1 = sat15(ay + ah);
    end

    // clip the pending box
    coord_t ex0, ey0, ex1, ey1, ew, eh;
    always_comb
    begin
        ex0 = (bx0_reg < 0) ? '0 : bx0_reg;
        ey0 = (by0_reg < 0) ? '0 : by0_reg;
        ex1 = (bx1_reg > coord_t'(scr_w_reg)) ? coord_t'(scr_w_reg) : bx1_reg;
        ey1 = (by1_reg > coord_t'(scr_h_reg)) ? coord_t'(scr_h_reg) : by1_reg;
        ew  = ex1 - ex0;
        eh  = ey1 - ey0;
    end

    assign stat.action       = act_reg;
    assign stat.scan_last    = (scan_reg == SLOT_W'(SLOTS - 1));
    assign stat.hit_found    = best_ok_reg;
    assign stat.press_edge   = lb_reg && !pleft_reg;
    assign stat.release_drag = !lb_reg;
    assign stat.drag_on      = drag_reg;
    assign stat.need_move    = drag_reg && (nx_reg != wl_reg[didx_reg]
                                            || ny_reg != wt_reg[didx_reg]);
    assign stat.ptr_moved    = (mx_reg != pmx_reg) || (my_reg != pmy_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg   <= 13'd1024;
            scr_h_reg   <= 13'd768;
            used_reg    <= '0;
            lnext_reg   <= '0;
            drag_reg    <= 1'b0;
            didx_reg    <= '0;
            gdx_reg     <= '0;
            gdy_reg     <= '0;
            pleft_reg   <= 1'b0;
            pmx_reg     <= '0;
            pmy_reg     <= '0;
            bv_reg      <= 1'b0;
            bx0_reg     <= '0;
            by0_reg     <= '0;
            bx1_reg     <= '0;
            by1_reg     <= '0;
            scan_reg    <= '0;
            best_ok_reg <= 1'b0;
            best_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_WIDTH)
                    scr_w_reg <= cfg_val;
                else
                    scr_h_reg <= cfg_val;
            end
            if (cmd.load)
            begin
                scan_reg    <= '0;
                best_ok_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (hit && (!best_ok_reg || wz_reg[scan_reg] > wz_reg[best_reg]))
                begin
                    best_ok_reg <= 1'b1;
                    best_reg    <= scan_reg;
                end
                if (!stat.scan_last)
                    scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.do_create && free_ok)
            begin
                used_reg[free_idx] <= 1'b1;
                lnext_reg          <= lnext_reg + 1;
            end
            if (cmd.press && best_ok_reg)
            begin
                drag_reg  <= 1'b1;
                didx_reg  <= best_reg;
                gdx_reg   <= 14'(coord_t'(mx_reg) - coord_t'(wl_reg[best_reg]));
                gdy_reg   <= 14'(coord_t'(my_reg) - coord_t'(wt_reg[best_reg]));
                lnext_reg <= lnext_reg + 1;
            end
            if (cmd.drag_calc)
            begin
                pleft_reg <= lb_reg;
                if (!stat.press_edge && stat.release_drag)
                    drag_reg <= 1'b0;
            end
            if (cmd.cur1 && stat.ptr_moved)
            begin
                pmx_reg <= mx_reg;
                pmy_reg <= my_reg;
            end
            if (add_en)
            begin
                bv_reg  <= 1'b1;
                bx0_reg <= (!bv_reg || ax0 < bx0_reg) ? ax0 : bx0_reg;
                by0_reg <= (!bv_reg || ay0 < by0_reg) ? ay0 : by0_reg;
                bx1_reg <= (!bv_reg || ax1 > bx1_reg) ? ax1 : bx1_reg;
                by1_reg <= (!bv_reg || ay1 > by1_reg) ? ay1 : by1_reg;
            end
            if (cmd.emit)
                bv_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= in_action;
            px_reg  <= in_pos_x;
            py_reg  <= in_pos_y;
            sw_reg  <= in_size_w;
            sh_reg  <= in_size_h;
            mx_reg  <= in_ptr_x;
            my_reg  <= in_ptr_y;
            lb_reg  <= in_left;
            ok_reg  <= 1'b0;
            oslot_reg  <= '0;
            redraw_reg <= 1'b0;
            ox_reg  <= '0;
            oy_reg  <= '0;
            ow_reg  <= '0;
            oh_reg  <= '0;
        end
        if (cmd.do_create && free_ok)
        begin
            wl_reg[free_idx] <= px_reg;
            wt_reg[free_idx] <= py_reg;
            ww_reg[free_idx] <= sw_reg;
            wh_reg[free_idx] <= sh_reg;
            wz_reg[free_idx] <= lnext_reg;
            ok_reg           <= 1'b1;
            oslot_reg        <= free_idx;
        end
        if (cmd.press && best_ok_reg)
            wz_reg[best_reg] <= lnext_reg;
        if (cmd.drag_calc)
        begin
            nx_reg <= 14'(dnx);
            ny_reg <= 14'(dny);
        end
        if (cmd.move && stat.need_move)
        begin
            wl_reg[didx_reg] <= nx_reg;
            wt_reg[didx_reg] <= ny_reg;
        end
        if (cmd.emit && bv_reg)
        begin
            redraw_reg <= 1'b1;
            ox_reg <= 13'(ex0);
            oy_reg <= 13'(ey0);
            ow_reg <= (ew < 0) ? '0 : 13'(ew);
            oh_reg <= (eh < 0) ? '0 : 13'(eh);
        end
    end

    // pack the result: ok, slot, redraw, x, y, w, h, drag, drag slot
    assign result = {3'(drag_reg ? didx_reg : '0), drag_reg, oh_reg, ow_reg,
                     oy_reg, ox_reg, redraw_reg, 3'(oslot_reg), ok_reg};
endmodule
